FILE: hw/rtl/rqra_pkg.sv
// ----------------------------------------------------------------------------
// rqra_pkg: shared types and constants for the ring queue running average
// Widths, payload structs, internal control structs and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rqra_pkg;

  // Ring size: one slot stays empty to tell full from empty.
  localparam int SLOTS  = 6;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS);
  localparam int TAG_W  = 16;
  localparam int HGT_W  = 12;
  localparam int HGT_MAX = (1 << HGT_W) - 1;
  localparam int SUM_W  = $clog2((SLOTS - 1) * HGT_MAX + 1);
  // Dividend is 2*sum + count, divisor is 2*count.
  localparam int NUM_W  = SUM_W + 2;
  localparam int DEN_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_INSERT  = 2'd0,
    STAT_REMOVED = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [TAG_W-1:0]   record_tag;
    logic [HGT_W-1:0]   record_height;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [HGT_W-1:0]   mean_height;
    logic [TAG_W-1:0]   removed_tag;
    logic [HGT_W-1:0]   removed_height;
  } out_item_t;

  // Sequencer to ring store.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Ring store to sequencer.
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rqra_ring.sv
// ----------------------------------------------------------------------------
// rqra_ring: circular record store with running sum and count
// Holds tags and heights, head and tail pointers, count and height sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rqra_ring (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rqra_pkg::ring_cmd_t         cmd,
  input  wire logic [rqra_pkg::TAG_W-1:0]  wr_tag,
  input  wire logic [rqra_pkg::HGT_W-1:0]  wr_height,
  output rqra_pkg::ring_stat_t             stat,
  output logic      [rqra_pkg::TAG_W-1:0]  rd_tag,
  output logic      [rqra_pkg::HGT_W-1:0]  rd_height,
  output logic      [rqra_pkg::SUM_W-1:0]  sum,
  output logic      [rqra_pkg::CNT_W-1:0]  count
);

  logic [rqra_pkg::TAG_W-1:0] tag_ring    [rqra_pkg::SLOTS];
  logic [rqra_pkg::HGT_W-1:0] height_ring [rqra_pkg::SLOTS];

  logic [rqra_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [rqra_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [rqra_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [rqra_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [rqra_pkg::TAG_W-1:0] rd_tag_r;
  logic [rqra_pkg::HGT_W-1:0] rd_height_r;
  logic                       drop;

  function automatic logic [rqra_pkg::IDX_W-1:0] next_idx(
    input logic [rqra_pkg::IDX_W-1:0] i
  );
    if (i == rqra_pkg::IDX_W'(rqra_pkg::SLOTS - 1)) begin
      return '0;
    end
    return i + rqra_pkg::IDX_W'(1);
  endfunction

  always_comb begin
    stat.full  = (next_idx(tail_r) == head_r);
    stat.empty = (head_r == tail_r);
    // Drop the oldest on a pop, or ahead of an insert into a full ring.
    drop      = cmd.pop | (cmd.push & stat.full);
    head_nxt  = drop ? next_idx(head_r) : head_r;
    tail_nxt  = cmd.push ? next_idx(tail_r) : tail_r;
    count_nxt = count_r - rqra_pkg::CNT_W'(drop) + rqra_pkg::CNT_W'(cmd.push);
    sum_nxt   = sum_r
              - (drop ? rqra_pkg::SUM_W'(rd_height_r) : '0)
              + (cmd.push ? rqra_pkg::SUM_W'(wr_height) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Store write at the tail, registered read of the head slot.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tag_ring[tail_r]    <= wr_tag;
      height_ring[tail_r] <= wr_height;
    end
    rd_tag_r    <= tag_ring[head_r];
    rd_height_r <= height_ring[head_r];
  end

  assign rd_tag    = rd_tag_r;
  assign rd_height = rd_height_r;
  assign sum       = sum_r;
  assign count     = count_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rqra_div.sv
// ----------------------------------------------------------------------------
// rqra_div: restoring divider, one quotient bit per cycle
// Takes a dividend and a non-zero divisor, pulses done with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rqra_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rqra_pkg::NUM_W-1:0]  num,
  input  wire logic [rqra_pkg::DEN_W-1:0]  den,
  output logic                             done,
  output logic      [rqra_pkg::NUM_W-1:0]  quo
);

  logic [rqra_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [rqra_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [rqra_pkg::DEN_W-1:0]  den_r;
  logic [rqra_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;
  logic [rqra_pkg::DEN_W:0]    trial;
  logic [rqra_pkg::DEN_W:0]    diff;
  logic                        ge;

  always_comb begin
    trial   = {rem_r, num_r[rqra_pkg::NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[rqra_pkg::DEN_W-1:0] : trial[rqra_pkg::DEN_W-1:0];
    num_nxt = {num_r[rqra_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + rqra_pkg::STEP_W'(1);
        if (step_r == rqra_pkg::STEP_W'(rqra_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ring_queue_running_average.sv
// ----------------------------------------------------------------------------
// ring_queue_running_average: record queue with rounded running mean height
//
// Input channel (in_valid / in_stall / in_item) carries one command per
// transfer: insert a tagged record, or remove the oldest record. The ring
// holds SLOTS-1 records; an insert into a full ring silently drops the
// oldest record first. Each command gives exactly one result transfer on
// out_valid / out_stall / out_item: an insert reports the mean height of
// the held records, rounded half up; a remove reports the popped tag and
// height, or an empty status when nothing is held.
//
// One command at a time. in_stall is high from the transfer until the
// result has been loaded into the output register. A remove passes
// through ST_UPDATE and ST_OUT; an insert through ST_UPDATE, ST_START,
// ST_DIV (the bit-serial divider forms (2*sum + count) / (2*count)) and
// ST_OUT. The next command can transfer once the sequencer is back idle.
// If the receiver stalls, the result holds in the output register and the
// next command may already transfer; its own result waits behind it.
// Synchronous reset empties the ring and clears the sum, count and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_queue_running_average (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rqra_pkg::in_item_t in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rqra_pkg::out_item_t out_item
);

  rqra_pkg::state_t     state_r, state_nxt;
  rqra_pkg::in_item_t   item_r;
  rqra_pkg::out_item_t  res_r, res_nxt;
  rqra_pkg::out_item_t  out_item_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 load_out;

  rqra_pkg::ring_cmd_t  ring_cmd;
  rqra_pkg::ring_stat_t ring_stat;
  logic [rqra_pkg::TAG_W-1:0] rd_tag;
  logic [rqra_pkg::HGT_W-1:0] rd_height;
  logic [rqra_pkg::SUM_W-1:0] sum;
  logic [rqra_pkg::CNT_W-1:0] count;

  logic                       div_start;
  logic                       div_done;
  logic [rqra_pkg::NUM_W-1:0] div_num;
  logic [rqra_pkg::DEN_W-1:0] div_den;
  logic [rqra_pkg::NUM_W-1:0] div_quo;

  logic in_xfer;

  assign in_stall = (state_r != rqra_pkg::ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;

  // Rounded mean: (2*sum + count) / (2*count), from the updated ring totals.
  assign div_num = {(rqra_pkg::NUM_W-1)'(sum), 1'b0} + rqra_pkg::NUM_W'(count);
  assign div_den = {count, 1'b0};

  rqra_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ring_cmd),
    .wr_tag    (item_r.record_tag),
    .wr_height (item_r.record_height),
    .stat      (ring_stat),
    .rd_tag    (rd_tag),
    .rd_height (rd_height),
    .sum       (sum),
    .count     (count)
  );

  rqra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer: next state, ring commands and the staged result.
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    ring_cmd      = '0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      rqra_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = rqra_pkg::ST_UPDATE;
        end
      end
      rqra_pkg::ST_UPDATE: begin
        res_nxt = '0;
        if (item_r.opcode == rqra_pkg::OP_INSERT) begin
          ring_cmd.push  = 1'b1;
          res_nxt.status = rqra_pkg::STAT_INSERT;
          state_nxt      = rqra_pkg::ST_START;
        end else if (ring_stat.empty) begin
          res_nxt.status = rqra_pkg::STAT_EMPTY;
          state_nxt      = rqra_pkg::ST_OUT;
        end else begin
          // Head read data is settled: the head last moved well before transfer.
          ring_cmd.pop           = 1'b1;
          res_nxt.status         = rqra_pkg::STAT_REMOVED;
          res_nxt.removed_tag    = rd_tag;
          res_nxt.removed_height = rd_height;
          state_nxt              = rqra_pkg::ST_OUT;
        end
      end
      rqra_pkg::ST_START: begin
        div_start = 1'b1;
        state_nxt = rqra_pkg::ST_DIV;
      end
      rqra_pkg::ST_DIV: begin
        if (div_done) begin
          res_nxt.mean_height = div_quo[rqra_pkg::HGT_W-1:0];
          state_nxt           = rqra_pkg::ST_OUT;
        end
      end
      rqra_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rqra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rqra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rqra_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture the command, stage and present the result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_item;
    end
    res_r <= res_nxt;
    if (load_out) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
